/* rtl/eatm_pkg.sv */
`timescale 1ns / 1ps
// eatm_pkg: layer table, derived constants and shared types of the
// exponential atmosphere density pipeline. No dependencies.
package eatm_pkg;

	// layer table size and the rows in use
	localparam int LAYER_COUNT = 28;
	localparam int TABLE_ROWS = 28;
	localparam int USED = (LAYER_COUNT < TABLE_ROWS) ? LAYER_COUNT : TABLE_ROWS;
	localparam int IDX_W = $clog2(USED);

	// fixed widths
	localparam int ALT_W = 22;
	localparam int H_W = 21;
	localparam int SCALE_W = 19;
	localparam int RECIP_W = 41;
	localparam int X_W = 41;
	localparam int N0_W = 10;
	localparam int N_W = 7;
	localparam int SERIES_TERMS = 13;
	localparam int KMUL_W = 37;
	localparam int KSHIFT = 36;

	localparam logic [31:0] LN2_Q32 = 32'd2977044472;
	localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;

	typedef logic [31:0] mant_arr_t [TABLE_ROWS];
	typedef logic signed [7:0] bexp_arr_t [TABLE_ROWS];
	typedef logic [RECIP_W-1:0] recip_arr_t [TABLE_ROWS];
	typedef logic [KMUL_W-1:0] kmul_arr_t [SERIES_TERMS+1];

	typedef struct packed {
		logic [31:0] m;
		logic signed [7:0] e;
	} norm_t;

	// item passed between the pipeline sections
	typedef struct packed {
		logic [31:0] t;
		logic [32:0] r;
		logic [IDX_W-1:0] idx;
		logic [N_W-1:0] n;
	} term_t;

	localparam logic [20:0] LAYER_BASE [TABLE_ROWS] = '{
		21'd0, 21'd25000, 21'd30000, 21'd40000, 21'd50000, 21'd60000, 21'd70000,
		21'd80000, 21'd90000, 21'd100000, 21'd110000, 21'd120000, 21'd130000,
		21'd140000, 21'd150000, 21'd180000, 21'd200000, 21'd250000, 21'd300000,
		21'd350000, 21'd400000, 21'd450000, 21'd500000, 21'd600000, 21'd700000,
		21'd800000, 21'd900000, 21'd1000000
	};

	localparam logic [13:0] LAYER_DIGITS [TABLE_ROWS] = '{
		14'd1225, 14'd3899, 14'd1774, 14'd3972, 14'd1057, 14'd3206, 14'd8770,
		14'd1905, 14'd3396, 14'd5297, 14'd9661, 14'd2438, 14'd8484, 14'd3845,
		14'd2070, 14'd5464, 14'd2789, 14'd7248, 14'd2418, 14'd9518, 14'd3725,
		14'd1585, 14'd6967, 14'd1454, 14'd3614, 14'd1170, 14'd5245, 14'd3019
	};

	localparam logic [4:0] LAYER_POW10 [TABLE_ROWS] = '{
		5'd3, 5'd5, 5'd5, 5'd6, 5'd6, 5'd7, 5'd8, 5'd8, 5'd9, 5'd10, 5'd11, 5'd11,
		5'd12, 5'd12, 5'd12, 5'd13, 5'd13, 5'd14, 5'd14, 5'd15, 5'd15, 5'd15,
		5'd16, 5'd16, 5'd17, 5'd17, 5'd18, 5'd18
	};

	localparam logic [SCALE_W-1:0] LAYER_SCALE [TABLE_ROWS] = '{
		19'd7249, 19'd6349, 19'd6682, 19'd7554, 19'd8382, 19'd7714, 19'd6549,
		19'd5799, 19'd5382, 19'd5877, 19'd7263, 19'd9473, 19'd12636, 19'd16149,
		19'd22523, 19'd29740, 19'd37105, 19'd45546, 19'd53628, 19'd53298,
		19'd58515, 19'd60828, 19'd63822, 19'd71835, 19'd88667, 19'd124640,
		19'd181050, 19'd268000
	};

	// restoring long division, elaboration use only
	function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
		logic [64:0] rem;
		logic [63:0] quo;
		rem = '0;
		quo = '0;
		for (int i = 63; i >= 0; i--) begin
			rem = {rem[63:0], num[i]};
			if (rem >= {1'b0, den}) begin
				rem = rem - {1'b0, den};
				quo[i] = 1'b1;
			end
		end
		return quo;
	endfunction

	// decimal base density to 32-bit normalized mantissa and exponent
	function automatic norm_t base_norm(input logic [13:0] digits, input logic [4:0] p);
		logic [63:0] a;
		logic [63:0] b;
		logic [63:0] m;
		int e;
		norm_t res;
		a = 64'(digits);
		b = 64'd1;
		m = '0;
		e = 0;
		for (int i = 0; i < int'(p); i++)
			b = b * 64'd10;
		while (a >= (b << 1)) begin
			b = b << 1;
			e++;
		end
		while (a < b) begin
			a = a << 1;
			e--;
		end
		for (int i = 0; i < 32; i++) begin
			m = m << 1;
			if (a >= b) begin
				a = a - b;
				m[0] = 1'b1;
			end
			a = a << 1;
		end
		res.m = m[31:0];
		res.e = 8'(e);
		return res;
	endfunction

	function automatic mant_arr_t build_mant();
		mant_arr_t a;
		norm_t nv;
		for (int i = 0; i < TABLE_ROWS; i++) begin
			nv = base_norm(LAYER_DIGITS[i], LAYER_POW10[i]);
			a[i] = nv.m;
		end
		return a;
	endfunction

	function automatic bexp_arr_t build_bexp();
		bexp_arr_t a;
		norm_t nv;
		for (int i = 0; i < TABLE_ROWS; i++) begin
			nv = base_norm(LAYER_DIGITS[i], LAYER_POW10[i]);
			a[i] = nv.e;
		end
		return a;
	endfunction

	// floor(2^53 / scale height)
	function automatic recip_arr_t build_recip();
		recip_arr_t a;
		for (int i = 0; i < TABLE_ROWS; i++)
			a[i] = RECIP_W'(udiv64(64'd1 << 53, 64'(LAYER_SCALE[i])));
		return a;
	endfunction

	// ceil(2^36 / k), exact quotient for any 32-bit dividend
	function automatic kmul_arr_t build_kmul();
		kmul_arr_t a;
		a[0] = '0;
		for (int k = 1; k <= SERIES_TERMS; k++)
			a[k] = KMUL_W'(udiv64((64'd1 << KSHIFT) + 64'(k - 1), 64'(k)));
		return a;
	endfunction

	localparam mant_arr_t BASE_MANT = build_mant();
	localparam bexp_arr_t BASE_EXP = build_bexp();
	localparam recip_arr_t SCALE_RECIP = build_recip();
	localparam kmul_arr_t KDIV_MUL = build_kmul();
	localparam logic [N0_W-1:0] LN2_RECIP = N0_W'(udiv64(64'd1 << 41, 64'(LN2_Q32)));

endpackage

/* rtl/eatm_query_if.sv */
`timescale 1ns / 1ps
// eatm_query_if: altitude query channel, valid/ready with payload.
// Depends on eatm_pkg.
interface eatm_query_if;
	logic valid;
	logic ready;
	logic signed [eatm_pkg::ALT_W-1:0] altitude;

	modport source(output valid, output altitude, input ready);
	modport sink(input valid, input altitude, output ready);
endinterface

/* rtl/eatm_result_if.sv */
`timescale 1ns / 1ps
// eatm_result_if: density result channel, valid/ready with payload.
// No dependencies.
interface eatm_result_if;
	logic valid;
	logic ready;
	logic [23:0] density_mantissa;
	logic signed [6:0] density_exponent;

	modport source(output valid, output density_mantissa, output density_exponent, input ready);
	modport sink(input valid, input density_mantissa, input density_exponent, output ready);
endinterface

/* rtl/exponential_atmosphere_density.sv */
`timescale 1ns / 1ps
// exponential_atmosphere_density: top level, altitude in, density float out.
// Depends on eatm_pkg, eatm_query_if, eatm_result_if, eatm_scale,
// eatm_exp_term and eatm_norm.
//
//   channel   role    payload
//   query     sink    altitude (22 bit signed, metres)
//   result    source  density_mantissa (24 bit 1.23), density_exponent (7 bit signed)
//
// one transfer per cycle sustained while the result is accepted; 8 scale stages,
// 13 series steps of 2 stages each, 2 normalize stages
// every stage has its own valid bit and load enable, so bubbles close up
// and a stalled result does not stop new queries until the stages are full
// reset clears only the valid bits; no clearing pass
module exponential_atmosphere_density (
	input  logic        clk,
	input  logic        arst_n,
	eatm_query_if.sink  query,
	eatm_result_if.source result
);

	localparam int NT = eatm_pkg::SERIES_TERMS;

	logic tvld [NT+1];
	logic trdy [NT+1];
	eatm_pkg::term_t tdat [NT+1];

	// height over scale height and ln2 reduction
	eatm_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.query     (query),
		.out_valid (tvld[0]),
		.out_ready (trdy[0]),
		.out_data  (tdat[0])
	);

	// Horner chain of exp(-t), highest term first
	for (genvar j = 0; j < NT; j++) begin : g_term
		eatm_exp_term u_term (
			.clk       (clk),
			.arst_n    (arst_n),
			.k         (4'(NT - j)),
			.in_valid  (tvld[j]),
			.in_ready  (trdy[j]),
			.in_data   (tdat[j]),
			.out_valid (tvld[j+1]),
			.out_ready (trdy[j+1]),
			.out_data  (tdat[j+1])
		);
	end

	// scale by base density and round
	eatm_norm u_norm (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (tvld[NT]),
		.in_ready (trdy[NT]),
		.in_data  (tdat[NT]),
		.result   (result)
	);

	// reduced argument stays below ln2
	a_t_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		tvld[0] |-> (tdat[0].t < eatm_pkg::LN2_Q32))
		else $error("reduced argument not below ln2");

	// mantissa always normalized
	a_mant_norm: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> result.density_mantissa[23])
		else $error("result mantissa not normalized");

	// exponent within the range -64 to 1
	a_exp_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.density_exponent >= -8'sd64) &&
		                 (result.density_exponent <= 8'sd1))
		else $error("result exponent out of range");

endmodule

/* rtl/eatm_scale.sv */
`timescale 1ns / 1ps
// eatm_scale: layer select, h / H in Q32 and reduction by ln2, eight stages.
// Depends on eatm_pkg and eatm_query_if.
module eatm_scale (
	input  logic            clk,
	input  logic            arst_n,
	eatm_query_if.sink      query,
	output logic            out_valid,
	input  logic            out_ready,
	output eatm_pkg::term_t out_data
);

	localparam int IW = eatm_pkg::IDX_W;
	localparam int XW = eatm_pkg::X_W;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic ld_s1, ld_s2, ld_s3, ld_s4, ld_s5, ld_s6, ld_s7, ld_s8;

	logic [IW-1:0] idx_s1, idx_s2, idx_s3, idx_s4, idx_s5, idx_s6, idx_s7, idx_s8;
	logic [20:0] h_s1, h_s2, h_s3, h_s4;
	logic [41:0] pp_lo_s2;
	logic [40:0] pp_hi_s2;
	logic [XW-1:0] q0_s3, q0_s4;
	logic [60:0] prod_s4;
	logic [XW-1:0] x_s5, x_s6;
	logic [eatm_pkg::N0_W-1:0] n0_s6, n0_s7;
	logic [32:0] t0_s7;
	logic [31:0] t_s8;
	logic [eatm_pkg::N_W-1:0] n_s8;

	logic pos;
	logic [20:0] ua;
	logic [IW-1:0] sel;
	logic [20:0] hsel;
	logic [XW-1:0] q0_inc;
	logic [eatm_pkg::N0_W:0] n_inc;

	// per-stage load enables, bubbles collapse
	assign ld_s8 = !v_s8 || out_ready;
	assign ld_s7 = !v_s7 || ld_s8;
	assign ld_s6 = !v_s6 || ld_s7;
	assign ld_s5 = !v_s5 || ld_s6;
	assign ld_s4 = !v_s4 || ld_s5;
	assign ld_s3 = !v_s3 || ld_s4;
	assign ld_s2 = !v_s2 || ld_s3;
	assign ld_s1 = !v_s1 || ld_s2;
	assign query.ready = ld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
			v_s5 <= 1'b0; v_s6 <= 1'b0; v_s7 <= 1'b0; v_s8 <= 1'b0;
		end else begin
			if (ld_s1) v_s1 <= query.valid;
			if (ld_s2) v_s2 <= v_s1;
			if (ld_s3) v_s3 <= v_s2;
			if (ld_s4) v_s4 <= v_s3;
			if (ld_s5) v_s5 <= v_s4;
			if (ld_s6) v_s6 <= v_s5;
			if (ld_s7) v_s7 <= v_s6;
			if (ld_s8) v_s8 <= v_s7;
		end
	end

	// layer select: highest base at or below a positive altitude
	always_comb begin
		pos = !query.altitude[eatm_pkg::ALT_W-1] && (query.altitude != '0);
		ua = query.altitude[20:0];
		sel = '0;
		for (int i = 1; i < eatm_pkg::USED; i++)
			if (ua >= eatm_pkg::LAYER_BASE[i])
				sel = IW'(i);
		if (!pos)
			sel = '0;
		hsel = pos ? (ua - eatm_pkg::LAYER_BASE[sel]) : '0;
	end

	assign q0_inc = q0_s3 + XW'(1);
	assign n_inc = {1'b0, n0_s7} + 11'd1;

	always_ff @(posedge clk) begin
		// stage 1: layer and height above base
		if (ld_s1) begin
			idx_s1 <= sel;
			h_s1 <= hsel;
		end
		// stage 2: partial products of h times 2^53 / H
		if (ld_s2) begin
			idx_s2 <= idx_s1;
			h_s2 <= h_s1;
			pp_lo_s2 <= 42'(h_s1) * 42'(eatm_pkg::SCALE_RECIP[idx_s1][20:0]);
			pp_hi_s2 <= 41'(h_s1) * 41'(eatm_pkg::SCALE_RECIP[idx_s1][40:21]);
		end
		// stage 3: quotient estimate, low by at most one
		if (ld_s3) begin
			idx_s3 <= idx_s2;
			h_s3 <= h_s2;
			q0_s3 <= XW'((62'(pp_lo_s2) + (62'(pp_hi_s2) << 21)) >> 21);
		end
		// stage 4: product of the next quotient and H
		if (ld_s4) begin
			idx_s4 <= idx_s3;
			h_s4 <= h_s3;
			q0_s4 <= q0_s3;
			prod_s4 <= 61'(q0_inc) * 61'(eatm_pkg::LAYER_SCALE[idx_s3]);
		end
		// stage 5: quotient correction gives x
		if (ld_s5) begin
			idx_s5 <= idx_s4;
			x_s5 <= (61'({h_s4, 32'b0}) >= prod_s4) ? q0_s4 + XW'(1) : q0_s4;
		end
		// stage 6: estimate of x / ln2
		if (ld_s6) begin
			idx_s6 <= idx_s5;
			x_s6 <= x_s5;
			n0_s6 <= eatm_pkg::N0_W'((51'(x_s5) * 51'(eatm_pkg::LN2_RECIP)) >> 41);
		end
		// stage 7: remainder before correction
		if (ld_s7) begin
			idx_s7 <= idx_s6;
			n0_s7 <= n0_s6;
			t0_s7 <= 33'(x_s6 - XW'(42'(n0_s6) * 42'(eatm_pkg::LN2_Q32)));
		end
		// stage 8: remainder correction, n saturates where the result underflows
		if (ld_s8) begin
			idx_s8 <= idx_s7;
			if (t0_s7 >= 33'(eatm_pkg::LN2_Q32)) begin
				t_s8 <= 32'(t0_s7 - 33'(eatm_pkg::LN2_Q32));
				n_s8 <= (n_inc > 11'd127) ? 7'd127 : 7'(n_inc);
			end else begin
				t_s8 <= t0_s7[31:0];
				n_s8 <= (n0_s7 > 10'd127) ? 7'd127 : 7'(n0_s7);
			end
		end
	end

	assign out_valid = v_s8;
	assign out_data.t = t_s8;
	assign out_data.r = eatm_pkg::ONE_Q32;
	assign out_data.idx = idx_s8;
	assign out_data.n = n_s8;

endmodule

/* rtl/eatm_exp_term.sv */
`timescale 1ns / 1ps
// eatm_exp_term: one Horner step of exp(-t), r = 1 - t * r / k, two stages.
// Depends on eatm_pkg.
module eatm_exp_term (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [3:0]      k,
	input  logic            in_valid,
	output logic            in_ready,
	input  eatm_pkg::term_t in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output eatm_pkg::term_t out_data
);

	logic v_s1, v_s2, ld_s1, ld_s2;
	eatm_pkg::term_t d_s1, d_s2;
	logic [31:0] tr_s1;
	logic [64:0] tr_full;
	logic [68:0] qk_full;

	assign ld_s2 = !v_s2 || out_ready;
	assign ld_s1 = !v_s1 || ld_s2;
	assign in_ready = ld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (ld_s1) v_s1 <= in_valid;
			if (ld_s2) v_s2 <= v_s1;
		end
	end

	// t * r in Q32, and exact division by k through its reciprocal
	assign tr_full = 65'(in_data.t) * 65'(in_data.r);
	assign qk_full = 69'(tr_s1) * 69'(eatm_pkg::KDIV_MUL[k]);

	always_ff @(posedge clk) begin
		if (ld_s1) begin
			d_s1 <= in_data;
			tr_s1 <= tr_full[63:32];
		end
		if (ld_s2) begin
			d_s2 <= '{t: d_s1.t,
			          r: eatm_pkg::ONE_Q32 - {1'b0, qk_full[67:36]},
			          idx: d_s1.idx,
			          n: d_s1.n};
		end
	end

	assign out_valid = v_s2;
	assign out_data = d_s2;

endmodule

/* rtl/eatm_norm.sv */
`timescale 1ns / 1ps
// eatm_norm: base density times exp term, rounding to 24 bits and exponent.
// Depends on eatm_pkg and eatm_result_if.
module eatm_norm (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  eatm_pkg::term_t in_data,
	eatm_result_if.source   result
);

	logic v_s1, v_s2, ld_s1, ld_s2;
	logic [63:0] p_s1;
	logic signed [7:0] be_s1;
	logic [eatm_pkg::N_W-1:0] n_s1;
	logic [23:0] mant_s2;
	logic signed [6:0] ex_s2;

	logic [64:0] p_full;
	logic [5:0] top;
	logic [24:0] mant;
	logic signed [9:0] ex;

	assign ld_s2 = !v_s2 || result.ready;
	assign ld_s1 = !v_s1 || ld_s2;
	assign in_ready = ld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (ld_s1) v_s1 <= in_valid;
			if (ld_s2) v_s2 <= v_s1;
		end
	end

	assign p_full = 65'(eatm_pkg::BASE_MANT[in_data.idx]) * 65'(in_data.r);

	// round half up to 24 bits, carry out and underflow saturation
	always_comb begin
		top = p_s1[63] ? 6'd63 : 6'd62;
		mant = p_s1[63] ? (25'(p_s1[63:40]) + 25'(p_s1[39]))
		                : (25'(p_s1[62:39]) + 25'(p_s1[38]));
		ex = 10'(top) + 10'(be_s1) - 10'sd63 - 10'(n_s1);
		if (mant[24]) begin
			mant = 25'h080_0000;
			ex = ex + 10'sd1;
		end
		if (ex < -10'sd64) begin
			mant = 25'h080_0000;
			ex = -10'sd64;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s1) begin
			p_s1 <= p_full[63:0];
			be_s1 <= eatm_pkg::BASE_EXP[in_data.idx];
			n_s1 <= in_data.n;
		end
		if (ld_s2) begin
			mant_s2 <= mant[23:0];
			ex_s2 <= 7'(ex);
		end
	end

	assign result.valid = v_s2;
	assign result.density_mantissa = mant_s2;
	assign result.density_exponent = ex_s2;

endmodule

/* tb/exponential_atmosphere_density_tb.sv */
`timescale 1ns / 1ps
// exponential_atmosphere_density_tb: checks the density pipeline against a local
// layer-table predictor with random altitudes, random idling, random stalls and one long hold-off.
// Depends on eatm_pkg, eatm_query_if, eatm_result_if and the top level.
module exponential_atmosphere_density_tb;

	localparam int PIPE_LATENCY = 36;
	localparam int IDLE_LIMIT = 4000;
	localparam int RANDOM_ITEMS = 1000;
	localparam int QUIET_ITEMS = 200;
	localparam int LONG_HOLD = 200;
	localparam int NROWS = 28;

	typedef struct {
		logic [23:0] mant;
		logic signed [6:0] expo;
	} density_t;

	typedef struct {
		logic signed [21:0] alt;
		bit typed;
		logic [23:0] mant;
		logic signed [6:0] expo;
	} stim_row_t;

	logic clk;
	logic arst_n;
	eatm_query_if query ();
	eatm_result_if result ();

	exponential_atmosphere_density dut (
		.clk(clk),
		.arst_n(arst_n),
		.query(query),
		.result(result)
	);

	// layer table held locally
	int unsigned base_tbl [NROWS] = '{0, 25000, 30000, 40000, 50000, 60000, 70000,
		80000, 90000, 100000, 110000, 120000, 130000, 140000, 150000, 180000, 200000,
		250000, 300000, 350000, 400000, 450000, 500000, 600000, 700000, 800000,
		900000, 1000000};
	int unsigned digit_tbl [NROWS] = '{1225, 3899, 1774, 3972, 1057, 3206, 8770,
		1905, 3396, 5297, 9661, 2438, 8484, 3845, 2070, 5464, 2789, 7248, 2418, 9518,
		3725, 1585, 6967, 1454, 3614, 1170, 5245, 3019};
	int unsigned pow_tbl [NROWS] = '{3, 5, 5, 6, 6, 7, 8, 8, 9, 10, 11, 11, 12, 12,
		12, 13, 13, 14, 14, 15, 15, 15, 16, 16, 17, 17, 18, 18};
	int unsigned scale_tbl [NROWS] = '{7249, 6349, 6682, 7554, 8382, 7714, 6549,
		5799, 5382, 5877, 7263, 9473, 12636, 16149, 22523, 29740, 37105, 45546, 53628,
		53298, 58515, 60828, 63822, 71835, 88667, 124640, 181050, 268000};

	density_t expected_density [$];
	int err_count = 0;
	int idle_cycles = 0;
	bit quiet_phase = 0;
	bit hold_result = 0;
	bit timed_out = 0;

	// predicted density for one altitude
	function automatic density_t predict_density(input logic signed [21:0] alt);
		int unsigned used;
		int unsigned idx;
		logic [63:0] h, x, n, t, r, a, b, m, p, mant;
		int be, top, sh, ex;
		density_t d;
		used = (eatm_pkg::LAYER_COUNT < NROWS) ? eatm_pkg::LAYER_COUNT : NROWS;
		if (used < 1)
			used = 1;
		idx = 0;
		h = 0;
		if (alt > 0) begin
			for (int i = 1; i < used; i++)
				if (int'(alt) >= base_tbl[i])
					idx = i;
			h = 64'(int'(alt) - base_tbl[idx]);
		end
		x = (h << 32) / 64'(scale_tbl[idx]);
		n = x / 64'd2977044472;
		t = x - n * 64'd2977044472;
		r = 64'h1_0000_0000;
		for (int k = 13; k >= 1; k--)
			r = 64'h1_0000_0000 - ((t * r) >> 32) / 64'(k);
		// base density normalised to [2^31, 2^32)
		a = digit_tbl[idx];
		b = 1;
		be = 0;
		m = 0;
		for (int i = 0; i < pow_tbl[idx]; i++)
			b = b * 10;
		while (a >= 2 * b) begin
			b = b << 1;
			be++;
		end
		while (a < b) begin
			a = a << 1;
			be--;
		end
		for (int i = 0; i < 32; i++) begin
			m = m << 1;
			if (a >= b) begin
				a = a - b;
				m[0] = 1'b1;
			end
			a = a << 1;
		end
		p = m * r;
		top = p[63] ? 63 : 62;
		sh = top - 23;
		mant = (p >> sh) + ((p >> (sh - 1)) & 64'd1);
		ex = top + be - 63 - int'(n);
		if (mant >= 64'd16777216) begin
			mant = 64'd8388608;
			ex++;
		end
		if (ex < -64) begin
			mant = 64'd8388608;
			ex = -64;
		end
		d.mant = mant[23:0];
		d.expo = 7'(ex);
		return d;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		err_count++;
	endtask

	// clock
	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// reset
	initial begin
		arst_n = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
	end

	// send one altitude, with random idling before it unless quiet
	task automatic send_altitude(input logic signed [21:0] alt);
		if (!quiet_phase && $urandom_range(0, 5) == 0) begin
			query.valid <= 0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
		query.valid <= 1;
		query.altitude <= alt;
		expected_density.push_back(predict_density(alt));
		@(posedge clk);
		while (!query.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic signed [21:0] random_altitude();
		int sel;
		sel = $urandom_range(0, 9);
		case (sel)
			0: return 22'($urandom);
			1: return -22'($urandom_range(0, 131072));
			2: return 22'(base_tbl[$urandom_range(0, NROWS - 1)] + $urandom_range(0, 2) - 1);
			3: return 22'($urandom_range(1000000, 2097151));
			default: return 22'($urandom_range(0, 1000000));
		endcase
	endfunction

	// stimulus
	initial begin
		stim_row_t rows [$];
		query.valid = 0;
		query.altitude = '0;
		// sea-level rows typed in: 1.225 rounds to 10276045 * 2^-23; others predicted
		rows.push_back('{22'sd0, 1, 24'd10276045, 7'sd0});
		rows.push_back('{-22'sd1, 1, 24'd10276045, 7'sd0});
		rows.push_back('{-22'sd2097152, 1, 24'd10276045, 7'sd0});
		rows.push_back('{22'sd1, 0, 24'd0, 7'sd0});
		rows.push_back('{22'sd24999, 0, 24'd0, 7'sd0});
		rows.push_back('{22'sd25000, 0, 24'd0, 7'sd0});
		rows.push_back('{22'sd150000, 0, 24'd0, 7'sd0});
		rows.push_back('{22'sd999999, 0, 24'd0, 7'sd0});
		rows.push_back('{22'sd1000000, 0, 24'd0, 7'sd0});
		rows.push_back('{22'sd1500000, 0, 24'd0, 7'sd0});
		rows.push_back('{22'sd2097151, 0, 24'd0, 7'sd0});
		rows.push_back('{22'sd1398101, 0, 24'd0, 7'sd0});
		rows.push_back('{22'sd699050, 0, 24'd0, 7'sd0});
		@(posedge arst_n);
		@(negedge clk);
		foreach (rows[i]) begin
			send_altitude(rows[i].alt);
			if (rows[i].typed) begin
				if (expected_density[$].mant != rows[i].mant ||
				    expected_density[$].expo != rows[i].expo)
					report_mismatch("sea-level table", expected_density[$].mant,
					                rows[i].mant);
			end
		end
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == 300) begin
				// sender pause until drained
				query.valid <= 0;
				while (expected_density.size() != 0)
					@(negedge clk);
			end
			if (i == 500)
				hold_result = 1;
			if (i == RANDOM_ITEMS - QUIET_ITEMS)
				quiet_phase = 1;
			send_altitude(random_altitude());
		end
		query.valid <= 0;
	end

	// receiver: random stalls, plus one long hold-off
	initial begin
		result.ready = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_result) begin
				result.ready <= 0;
				repeat (LONG_HOLD) @(negedge clk);
				hold_result = 0;
				result.ready <= 1;
			end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
				result.ready <= 0;
				repeat ($urandom_range(1, 12) - 1) @(negedge clk);
			end else begin
				result.ready <= 1;
			end
		end
	end

	// result check at each transfer
	always @(posedge clk) begin
		density_t want;
		if (arst_n && result.valid && result.ready) begin
			if (expected_density.size() == 0) begin
				report_mismatch("unexpected result", result.density_mantissa, 0);
			end else begin
				want = expected_density.pop_front();
				if (result.density_mantissa !== want.mant)
					report_mismatch("mantissa", result.density_mantissa, want.mant);
				if (result.density_exponent !== want.expo)
					report_mismatch("exponent", result.density_exponent, want.expo);
			end
		end
	end

	// watchdog on cycles with no transfer
	always @(posedge clk) begin
		if ((query.valid && query.ready) || (result.valid && result.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT)
			timed_out = 1;
	end

	// end of run
	initial begin
		@(posedge arst_n);
		wait (quiet_phase || timed_out);
		while (!timed_out && (query.valid || expected_density.size() != 0))
			@(posedge clk);
		if (!timed_out)
			repeat (PIPE_LATENCY * 2) @(posedge clk);
		if (timed_out)
			$display("CHECKS FAILED");
		else if (err_count == 0 && expected_density.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

/* files.f */
rtl/eatm_pkg.sv
rtl/eatm_query_if.sv
rtl/eatm_result_if.sv
rtl/eatm_scale.sv
rtl/eatm_exp_term.sv
rtl/eatm_norm.sv
rtl/exponential_atmosphere_density.sv
tb/exponential_atmosphere_density_tb.sv
